### sv/u8dec_pkg.sv
`default_nettype none

package u8dec_pkg;

    localparam int unsigned CP_W       = 32;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned PAYLOAD_W  = 7;
    localparam int unsigned CONT_BITS  = 6;
    localparam int unsigned REM_W      = 3;

    // queue between front and back; depth must stay a power of two
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CLS_ASCII = 2'd0,
        CLS_CONT  = 2'd1,
        CLS_LEAD  = 2'd2
    } byte_class_t;

    typedef struct packed {
        byte_class_t            cls;
        logic [REM_W-1:0]       cont_count;  // continuations a lead opens
        logic [PAYLOAD_W-1:0]   payload;     // data bits of the byte
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

endpackage

`default_nettype wire

### sv/u8dec_front.sv
`default_nettype none

module u8dec_front (
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [u8dec_pkg::BYTE_W-1:0]     byte_in,
    input  wire logic                             queue_full,
    output logic                                  push,
    output u8dec_pkg::item_t                      push_item
);

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        push_item.cls        = u8dec_pkg::CLS_LEAD;
        push_item.cont_count = '0;
        push_item.payload    = '0;
        case (byte_in) inside
            [8'h00:8'h7F]:
            begin
                push_item.cls     = u8dec_pkg::CLS_ASCII;
                push_item.payload = byte_in[6:0];
            end
            [8'h80:8'hBF]:
            begin
                push_item.cls     = u8dec_pkg::CLS_CONT;
                push_item.payload = {1'b0, byte_in[5:0]};
            end
            [8'hC0:8'hDF]:
            begin
                push_item.cont_count = 3'd1;
                push_item.payload    = {2'b0, byte_in[4:0]};
            end
            [8'hE0:8'hEF]:
            begin
                push_item.cont_count = 3'd2;
                push_item.payload    = {3'b0, byte_in[3:0]};
            end
            [8'hF0:8'hF7]:
            begin
                push_item.cont_count = 3'd3;
                push_item.payload    = {4'b0, byte_in[2:0]};
            end
            [8'hF8:8'hFB]:
            begin
                push_item.cont_count = 3'd4;
                push_item.payload    = {5'b0, byte_in[1:0]};
            end
            [8'hFC:8'hFD]:
            begin
                push_item.cont_count = 3'd5;
                push_item.payload    = {6'b0, byte_in[0]};
            end
            8'hFE:
            begin
                push_item.cont_count = 3'd6;
            end
            default:
            begin
                // 0xFF: no payload, seven continuations
                push_item.cont_count = 3'd7;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/u8dec_queue.sv
`default_nettype none

module u8dec_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire u8dec_pkg::item_t     push_item,
    output logic                      full,
    input  wire logic                 pop,
    output u8dec_pkg::queue_head_t    head
);

    u8dec_pkg::item_t                       mem [u8dec_pkg::QUEUE_DEPTH];
    logic [u8dec_pkg::QUEUE_AW-1:0]         wr_ptr_reg;
    logic [u8dec_pkg::QUEUE_AW-1:0]         rd_ptr_reg;
    logic [u8dec_pkg::QUEUE_CW-1:0]         count_reg;
    logic [u8dec_pkg::QUEUE_CW-1:0]         count_next;

    assign full       = (count_reg == u8dec_pkg::QUEUE_CW'(u8dec_pkg::QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.item  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !head.valid |-> !pop)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= u8dec_pkg::QUEUE_CW'(u8dec_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

### sv/u8dec_back.sv
`default_nettype none

module u8dec_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire u8dec_pkg::queue_head_t           head,
    output logic                                  pop,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [u8dec_pkg::CP_W-1:0]            code_point,
    output logic                                  bad_sequence,
    output logic                                  last_of_run
);

    logic [u8dec_pkg::REM_W-1:0]  rem_reg;
    logic [u8dec_pkg::REM_W-1:0]  rem_next;
    logic [u8dec_pkg::CP_W-1:0]   acc_reg;
    logic [u8dec_pkg::CP_W-1:0]   acc_next;
    logic                         pend_reg;     // second result of a zero byte owed
    logic                         pend_next;
    logic                         out_valid_reg;
    logic [u8dec_pkg::CP_W-1:0]   cp_reg;
    logic                         bad_reg;
    logic                         last_reg;

    logic                         load_ok;
    logic                         emit;
    logic [u8dec_pkg::CP_W-1:0]   emit_cp;
    logic                         emit_bad;
    logic                         emit_last;
    logic                         emit_two;
    logic [u8dec_pkg::CP_W-1:0]   acc_shift;
    logic [u8dec_pkg::REM_W-1:0]  rem_dec;
    logic                         load;

    assign out_valid    = out_valid_reg;
    assign code_point   = cp_reg;
    assign bad_sequence = bad_reg;
    assign last_of_run  = last_reg;

    assign load_ok   = !out_valid_reg || !out_stall;
    assign acc_shift = {acc_reg[u8dec_pkg::CP_W-u8dec_pkg::CONT_BITS-1:0],
                        head.item.payload[u8dec_pkg::CONT_BITS-1:0]};
    assign rem_dec   = rem_reg - 1'b1;

    // what the head item does to state and output
    always_comb
    begin
        emit      = 1'b0;
        emit_cp   = '0;
        emit_bad  = 1'b0;
        emit_last = 1'b1;
        emit_two  = 1'b0;
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        if (rem_reg != '0)
        begin
            case (head.item.cls)
                u8dec_pkg::CLS_CONT:
                begin
                    rem_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        emit     = 1'b1;
                        emit_cp  = acc_shift;
                        acc_next = '0;
                    end
                    else
                    begin
                        acc_next = acc_shift;
                    end
                end
                default:
                begin
                    rem_next = '0;
                    acc_next = '0;
                    emit     = 1'b1;
                    emit_bad = 1'b1;
                    if (head.item.cls == u8dec_pkg::CLS_ASCII && head.item.payload == '0)
                    begin
                        emit_last = 1'b0;
                        emit_two  = 1'b1;
                    end
                end
            endcase
        end
        else
        begin
            case (head.item.cls)
                u8dec_pkg::CLS_ASCII:
                begin
                    emit    = 1'b1;
                    emit_cp = u8dec_pkg::CP_W'(head.item.payload);
                end
                u8dec_pkg::CLS_LEAD:
                begin
                    rem_next = head.item.cont_count;
                    acc_next = u8dec_pkg::CP_W'(head.item.payload);
                end
                default:
                begin
                    emit     = 1'b1;
                    emit_bad = 1'b1;
                end
            endcase
        end
    end

    assign pop  = head.valid && !pend_reg && (!emit || load_ok);
    assign load = load_ok && (pend_reg || (head.valid && emit));

    always_comb
    begin
        pend_next = pend_reg;
        if (pend_reg && load_ok)
        begin
            pend_next = 1'b0;
        end
        else if (pop && emit_two)
        begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (pend_reg)
            begin
                cp_reg   <= '0;
                bad_reg  <= 1'b0;
                last_reg <= 1'b1;
            end
            else
            begin
                cp_reg   <= emit_cp;
                bad_reg  <= emit_bad;
                last_reg <= emit_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            acc_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                rem_reg <= rem_next;
                acc_reg <= acc_next;
            end
            pend_reg <= pend_next;
            if (load_ok)
            begin
                out_valid_reg <= load;
            end
        end
    end

    a_pend_has_first: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (out_valid_reg && bad_reg && !last_reg))
        else $error("second result owed without the error result in front");

    a_idle_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg == '0) |-> (acc_reg == '0))
        else $error("accumulator not cleared outside a sequence");

    a_not_last_only_first: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> pend_reg)
        else $error("non-final result without a follow-up");

    a_no_pop_while_pend: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !pop)
        else $error("item taken while a result is owed");

endmodule

`default_nettype wire

### sv/utf8_stream_decoder.sv
`default_nettype none

// Channel   Dir   Handshake             Payload
// input     in    in_valid / in_stall   byte_in[7:0]
// output    out   out_valid / out_stall code_point[31:0], bad_sequence, last_of_run
//
// One byte per cycle unless in_stall; each result is registered after the queue.
// A zero byte in a sequence yields two results and holds back the next queue pop.
// in_stall rises only when the two-entry queue between classifier and decoder is full.
// The output register takes a new result in the same cycle the old one is taken.
// Reset empties the queue and clears the pending count and accumulator.
module utf8_stream_decoder (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [u8dec_pkg::BYTE_W-1:0]     byte_in,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [u8dec_pkg::CP_W-1:0]            code_point,
    output logic                                  bad_sequence,
    output logic                                  last_of_run
);

    logic                       push;
    u8dec_pkg::item_t           push_item;
    logic                       queue_full;
    logic                       pop;
    u8dec_pkg::queue_head_t     head;

    u8dec_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .byte_in    (byte_in),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    u8dec_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head       (head)
    );

    u8dec_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .code_point   (code_point),
        .bad_sequence (bad_sequence),
        .last_of_run  (last_of_run)
    );

endmodule

`default_nettype wire

### verif/tb_top.sv
module tb_top;

    localparam int unsigned STALL_PCT   = 19;
    localparam int unsigned STALL_LIMIT = 1000;
    localparam int unsigned RANDOM_BYTES = 650;

    typedef struct {
        logic [u8dec_pkg::CP_W-1:0] cp;
        logic                       bad;
        logic                       last;
    } cp_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [u8dec_pkg::BYTE_W-1:0]   byte_in = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [u8dec_pkg::CP_W-1:0]     code_point;
    logic                           bad_sequence;
    logic                           last_of_run;

    // decoder state as seen by the predictor
    logic [u8dec_pkg::REM_W-1:0]    seq_left = '0;
    logic [u8dec_pkg::CP_W-1:0]     seq_acc = '0;

    cp_result_t          decoded_q[$];
    int unsigned         mismatch_count = 0;
    int unsigned         bytes_sent = 0;
    int unsigned         quiet_cycles = 0;
    bit                  no_idle = 1'b0;

    utf8_stream_decoder u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .byte_in      (byte_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .code_point   (code_point),
        .bad_sequence (bad_sequence),
        .last_of_run  (last_of_run)
    );

    always #5 clk = ~clk;

    function automatic void decode_byte(input logic [u8dec_pkg::BYTE_W-1:0] b);
        int k;
        k = 0;
        while (k < 8 && b[7-k])
            k++;
        if (seq_left != 0)
        begin
            if (b == 8'h00)
            begin
                seq_left = '0;
                seq_acc  = '0;
                decoded_q.push_back('{cp: '0, bad: 1'b1, last: 1'b0});
                decoded_q.push_back('{cp: '0, bad: 1'b0, last: 1'b1});
            end
            else if (b[7:6] != 2'b10)
            begin
                seq_left = '0;
                seq_acc  = '0;
                decoded_q.push_back('{cp: '0, bad: 1'b1, last: 1'b1});
            end
            else
            begin
                seq_acc  = {seq_acc[u8dec_pkg::CP_W-u8dec_pkg::CONT_BITS-1:0],
                            b[u8dec_pkg::CONT_BITS-1:0]};
                seq_left = seq_left - 1'b1;
                if (seq_left == 0)
                begin
                    decoded_q.push_back('{cp: seq_acc, bad: 1'b0, last: 1'b1});
                    seq_acc = '0;
                end
            end
        end
        else if (!b[7])
            decoded_q.push_back('{cp: u8dec_pkg::CP_W'(b), bad: 1'b0, last: 1'b1});
        else if (k < 2)
            decoded_q.push_back('{cp: '0, bad: 1'b1, last: 1'b1});
        else
        begin
            seq_acc  = (k == 8) ? '0 : u8dec_pkg::CP_W'(b & (8'hFF >> k));
            seq_left = u8dec_pkg::REM_W'(k - 1);
        end
    endfunction

    // k = 1 gives a plain ASCII byte, k >= 2 a lead with k leading ones
    function automatic logic [u8dec_pkg::BYTE_W-1:0] rand_lead(input int k);
        logic [u8dec_pkg::BYTE_W-1:0] ones;
        if (k == 1)
            return u8dec_pkg::BYTE_W'($urandom_range(127));
        ones = 8'hFF << (8 - k);
        return ones | (u8dec_pkg::BYTE_W'($urandom) & (8'hFF >> (k + 1)));
    endfunction

    function automatic logic [u8dec_pkg::BYTE_W-1:0] rand_cont();
        return 8'h80 | (u8dec_pkg::BYTE_W'($urandom) & 8'h3F);
    endfunction

    task automatic send_byte(input logic [u8dec_pkg::BYTE_W-1:0] b);
        while (!no_idle && $urandom_range(99) < STALL_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_in  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_byte(b);
        bytes_sent++;
    endtask

    task automatic test_ascii();
        send_byte(8'h00);
        send_byte(8'h7F);
    endtask

    task automatic test_lone_continuation();
        send_byte(8'h80);
        send_byte(8'hBF);
    endtask

    task automatic test_full_sequences();
        send_byte(8'hC3);
        send_byte(8'hA9);
        // 0xFF lead: seven continuations, accumulator wraps past 32 bits
        send_byte(8'hFF);
        repeat (7)
            send_byte(8'hBF);
        // overlong zero passes through as a good code point
        send_byte(8'hC0);
        send_byte(8'h80);
    endtask

    task automatic test_broken_sequences();
        send_byte(8'hE2);
        send_byte(8'h41);
        send_byte(8'hC3);
        send_byte(8'h00);
        // a new lead inside a sequence ends it with an error result and opens no new sequence
        send_byte(8'hF0);
        send_byte(8'hC3);
    endtask

    task automatic test_random_stream();
        int kind;
        int k;
        int r;
        int n_cont;
        logic [u8dec_pkg::BYTE_W-1:0] brk;
        while (bytes_sent < RANDOM_BYTES + 22)
        begin
            no_idle = (bytes_sent >= 250 && bytes_sent < 400);
            kind = $urandom_range(99);
            r = $urandom_range(99);
            if (r < 30)
                k = 1;
            else if (r < 55)
                k = 2;
            else if (r < 75)
                k = 3;
            else if (r < 88)
                k = 4;
            else
                k = $urandom_range(8, 5);
            if (kind < 70)
            begin
                send_byte(rand_lead(k));
                repeat (k - 1)
                    send_byte(rand_cont());
            end
            else if (kind < 85)
            begin
                if (k < 2)
                    k = 2;
                n_cont = $urandom_range(k - 2);
                send_byte(rand_lead(k));
                repeat (n_cont)
                    send_byte(rand_cont());
                if ($urandom_range(2) == 0)
                    brk = 8'h00;
                else
                begin
                    brk = u8dec_pkg::BYTE_W'($urandom);
                    if (brk[7:6] == 2'b10)
                        brk[6] = 1'b1;
                end
                send_byte(brk);
            end
            else
                send_byte(u8dec_pkg::BYTE_W'($urandom));
        end
        no_idle = 1'b0;
    endtask

    always @(posedge clk)
        out_stall <= !no_idle && ($urandom_range(99) < STALL_PCT);

    always @(posedge clk)
    begin : check_results
        cp_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (decoded_q.size() == 0)
            begin
                $display("%0t: unexpected result code_point %h bad %b last %b",
                         $time, code_point, bad_sequence, last_of_run);
                mismatch_count++;
            end
            else
            begin
                e = decoded_q.pop_front();
                if (code_point !== e.cp)
                begin
                    $display("%0t: code_point expected %h actual %h", $time, e.cp, code_point);
                    mismatch_count++;
                end
                if (bad_sequence !== e.bad)
                begin
                    $display("%0t: bad_sequence expected %b actual %b",
                             $time, e.bad, bad_sequence);
                    mismatch_count++;
                end
                if (last_of_run !== e.last)
                begin
                    $display("%0t: last_of_run expected %b actual %b",
                             $time, e.last, last_of_run);
                    mismatch_count++;
                end
            end
        end
    end

    // stall watchdog: cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_ascii();
        test_lone_continuation();
        test_full_sequences();
        test_broken_sequences();
        test_random_stream();
        in_valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
